@@ hdl/random_unused_entry_picker_unit_defines.svh @@
// assertion macros for the random unused entry picker
`ifndef RANDOM_UNUSED_ENTRY_PICKER_UNIT_DEFINES_SVH
`define RANDOM_UNUSED_ENTRY_PICKER_UNIT_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define RUEP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RUEP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ruep_pkg.sv @@
// shared types and constants of the random unused entry picker
`timescale 1ns / 1ps

package ruep_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int IDX_W       = 8;
    localparam int SIZE_W      = 9;
    localparam int RAND_W      = 31;
    localparam int DIV_CNT_W   = 5;

    localparam logic REQ_CLEAR = 1'b0;
    localparam logic REQ_DRAW  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // second modulo works on a remainder below MAX_ENTRIES
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_FULL  = DIV_CNT_W'(RAND_W);
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_SHORT = DIV_CNT_W'(IDX_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_MOD2,
        ST_SEARCH,
        ST_DONE
    } ruep_state_t;

    // pool sizes above the mark array saturate
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size);
        return (size > SIZE_W'(MAX_ENTRIES)) ? SIZE_W'(MAX_ENTRIES) : size;
    endfunction

endpackage

@@ hdl/ruep_req_if.sv @@
// request and response channel interfaces
`timescale 1ns / 1ps

interface ruep_req_if
    import ruep_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [RAND_W-1:0] random_value;

    modport source (output valid, output req_type, output random_value, input ready);
    modport sink   (input valid, input req_type, input random_value, output ready);
endinterface

interface ruep_rsp_if
    import ruep_pkg::*;
    ;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] entry_index;
    logic             status;

    modport source (output valid, output entry_index, output status, input ready);
    modport sink   (input valid, input entry_index, input status, output ready);
endinterface

@@ hdl/random_unused_entry_picker_unit.sv @@
// random unused entry picker: draw without replacement over a configurable pool
//
// usage
//   cfg_wr_en / cfg_wr_data write pool_size (0..256, larger values saturate),
//   only while no transaction is in flight
//   req carries one transaction per request: req_type clear or draw, and
//   random_value for a draw; rsp returns one transaction per request with
//   entry_index and status (ok or fail)
// timing, n the pool size
//   clear, or any request on an empty pool: the sequencer goes straight to
//   its done state and the result is then registered at the output
//   draw: a restoring divider (one bit per cycle) takes random_value mod n in
//   31 steps while a scan counts free marks, then free-mark modulo in 8 steps,
//   then a second scan finds the entry; with no free entry it ends after the count scan
//   req.ready is high only while the sequencer is idle, one request at a time
// reset
//   pool_size 0, clean limit 0 so every mark reads unused, no result pending
// stall
//   a finished result waits in the output register; one more request may be
//   accepted meanwhile and its result is held back until rsp drains
`timescale 1ns / 1ps

module random_unused_entry_picker_unit
    import ruep_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data,
    ruep_req_if.sink          req,
    ruep_rsp_if.source        rsp
);

`include "random_unused_entry_picker_unit_defines.svh"

    ruep_state_t state_reg, state_next;

    // used marks, one bit per entry, read one address a cycle
    logic              marks_mem [MAX_ENTRIES];
    logic              rd_mark_reg;
    // entries at or above the clean limit read as unused whatever the memory holds;
    // the count scan writes them back to unused before moving the limit up
    logic [SIZE_W-1:0] clean_lim_reg, clean_lim_next;
    logic [SIZE_W-1:0] pool_size_reg, pool_size_next;

    // shared restoring divider
    logic [RAND_W-1:0]    div_q_reg, div_q_next;
    logic [SIZE_W-1:0]    div_rem_reg, div_rem_next;
    logic [SIZE_W-1:0]    divisor_reg, divisor_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    // scan counters
    logic [SIZE_W-1:0] scan_idx_reg, scan_idx_next;
    logic [SIZE_W-1:0] free_cnt_reg, free_cnt_next;
    logic [SIZE_W-1:0] seen_reg, seen_next;

    // result of the current request and the output register
    logic [IDX_W-1:0] res_index_reg, res_index_next;
    logic             res_status_reg, res_status_next;
    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] out_index_reg, out_index_next;
    logic             out_status_reg, out_status_next;

    logic [SIZE_W-1:0] n_eff;
    logic [SIZE_W-1:0] cfg_size;
    logic              req_fire;
    logic              div_busy;
    logic [SIZE_W:0]   div_trial;
    logic [SIZE_W-1:0] div_step_rem;
    logic              scan_mark;
    logic              scan_active;
    logic              out_free;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic              mem_wdata;
    logic [IDX_W-1:0]  rd_addr;

    assign n_eff       = eff_size(pool_size_reg);
    assign cfg_size    = eff_size(cfg_wr_data);
    assign req.ready   = (state_reg == ST_IDLE);
    assign req_fire    = req.valid && req.ready;
    assign div_busy    = (div_cnt_reg != '0);
    // read data is registered at the same edge as the scan index, so it lines up with scan_idx_reg
    assign rd_addr     = scan_idx_next[IDX_W-1:0];
    assign scan_mark   = (scan_idx_reg < clean_lim_reg) && rd_mark_reg;
    assign scan_active = (scan_idx_reg < n_eff);
    assign out_free    = !out_valid_reg || rsp.ready;

    // one divider step: shift in the next dividend bit, subtract when it fits
    assign div_trial    = {div_rem_reg, div_q_reg[RAND_W-1]};
    assign div_step_rem = (div_trial >= {1'b0, divisor_reg})
                          ? SIZE_W'(div_trial - {1'b0, divisor_reg})
                          : SIZE_W'(div_trial);

    assign rsp.valid       = out_valid_reg;
    assign rsp.entry_index = out_index_reg;
    assign rsp.status      = out_status_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (n_eff == '0 || req.req_type == REQ_CLEAR)
                        state_next = ST_DONE;
                    else
                        state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                if (!scan_active && !div_busy)
                    state_next = (free_cnt_reg == '0) ? ST_DONE : ST_MOD2;
            end
            ST_MOD2:
            begin
                if (!div_busy)
                    state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (!scan_mark && seen_reg == div_rem_reg)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        clean_lim_next  = clean_lim_reg;
        pool_size_next  = pool_size_reg;
        div_q_next      = div_q_reg;
        div_rem_next    = div_rem_reg;
        divisor_next    = divisor_reg;
        div_cnt_next    = div_cnt_reg;
        scan_idx_next   = scan_idx_reg;
        free_cnt_next   = free_cnt_reg;
        seen_next       = seen_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = scan_idx_reg[IDX_W-1:0];
        mem_wdata       = 1'b0;

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        // divider runs whenever it holds steps
        if (div_busy)
        begin
            div_rem_next = div_step_rem;
            div_q_next   = {div_q_reg[RAND_W-2:0], 1'b0};
            div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    res_index_next = '0;
                    if (n_eff == '0)
                        res_status_next = STATUS_FAIL;
                    else if (req.req_type == REQ_CLEAR)
                    begin
                        // every entry reads unused again, marks beyond the pool already are
                        clean_lim_next  = '0;
                        res_status_next = STATUS_OK;
                    end
                    else
                    begin
                        div_q_next    = req.random_value;
                        div_rem_next  = '0;
                        divisor_next  = n_eff;
                        div_cnt_next  = DIV_STEPS_FULL;
                        scan_idx_next = '0;
                        free_cnt_next = '0;
                    end
                end
            end
            ST_COUNT:
            begin
                if (scan_active)
                begin
                    scan_idx_next = scan_idx_reg + SIZE_W'(1);
                    // entries past the clean limit are written back to unused
                    if (scan_idx_reg >= clean_lim_reg)
                        mem_we = 1'b1;
                    if (!scan_mark)
                        free_cnt_next = free_cnt_reg + SIZE_W'(1);
                end
                else if (!div_busy)
                begin
                    clean_lim_next = n_eff;
                    if (free_cnt_reg == '0)
                    begin
                        res_index_next  = '0;
                        res_status_next = STATUS_FAIL;
                    end
                    else
                    begin
                        // remainder is below 256, only its low byte is divided
                        div_q_next   = {div_rem_reg[IDX_W-1:0], (RAND_W-IDX_W)'(0)};
                        div_rem_next = '0;
                        divisor_next = free_cnt_reg;
                        div_cnt_next = DIV_STEPS_SHORT;
                    end
                end
            end
            ST_MOD2:
            begin
                if (!div_busy)
                begin
                    scan_idx_next = '0;
                    seen_next     = '0;
                end
            end
            ST_SEARCH:
            begin
                scan_idx_next = scan_idx_reg + SIZE_W'(1);
                if (!scan_mark)
                begin
                    if (seen_reg == div_rem_reg)
                    begin
                        mem_we          = 1'b1;
                        mem_wdata       = 1'b1;
                        res_index_next  = scan_idx_reg[IDX_W-1:0];
                        res_status_next = STATUS_OK;
                    end
                    else
                        seen_next = seen_reg + SIZE_W'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = res_index_reg;
                    out_status_next = res_status_reg;
                end
            end
            default: ;
        endcase

        // pool size write only while idle, up to the user; entries past the new size read unused
        if (cfg_wr_en)
        begin
            pool_size_next = cfg_wr_data;
            if (cfg_size < clean_lim_next)
                clean_lim_next = cfg_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clean_lim_reg <= '0;
            pool_size_reg <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clean_lim_reg <= clean_lim_next;
            pool_size_reg <= pool_size_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_q_reg      <= div_q_next;
        div_rem_reg    <= div_rem_next;
        divisor_reg    <= divisor_next;
        scan_idx_reg   <= scan_idx_next;
        free_cnt_reg   <= free_cnt_next;
        seen_reg       <= seen_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        out_index_reg  <= out_index_next;
        out_status_reg <= out_status_next;
    end

    // mark memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            marks_mem[mem_waddr] <= mem_wdata;
        rd_mark_reg <= marks_mem[rd_addr];
    end

    // free count of the scan cannot pass the pool size
    `RUEP_ASSERT_ALWAYS(a_free_bound, state_reg != ST_COUNT || free_cnt_reg <= n_eff, "free count high")

    // the target rank is always below the free count during the search
    `RUEP_ASSERT_ALWAYS(a_target_bound, state_reg != ST_SEARCH || div_rem_reg < free_cnt_reg, "bad target")

    // the search never runs off the end of the pool
    `RUEP_ASSERT_ALWAYS(a_search_in_pool, state_reg != ST_SEARCH || scan_active, "search past pool end")

    // a successful draw leaves its entry marked used
    `RUEP_ASSERT_NEXT(a_draw_marks, state_reg == ST_SEARCH && state_next == ST_DONE, marks_mem[res_index_reg] && res_status_reg == STATUS_OK, "drawn entry not marked")

endmodule
